// ===== rtl/iirdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf_pkg
// Shared constants and types for the direct form I IIR filter.
// ----------------------------------------------------------------------------
package iirdf_pkg;

  // Filter sizes
  localparam int MAX_FF_TAPS = 16;
  localparam int MAX_FB_TAPS = 16;

  // Field and datapath widths
  localparam int SAMPLE_W    = 16;   // Q1.15
  localparam int COEF_W      = 18;   // Q4.14
  localparam int PROD_W      = SAMPLE_W + COEF_W;  // Q5.29
  localparam int ACC_W       = 48;
  localparam int FRAC_SHIFT  = 14;
  localparam int TAP_INDEX_W = 4;
  localparam int TAPS_W      = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int IDX_W       = $clog2(MAX_FF_TAPS > MAX_FB_TAPS ? MAX_FF_TAPS : MAX_FB_TAPS);
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam int TAPS_FF_MAX = MAX_FF_TAPS;
  localparam int TAPS_FB_MAX = MAX_FB_TAPS;

  // Input item kinds
  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_LOAD_FF  = 2'd1,
    OP_LOAD_FB  = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FF_TAPS = 1'b0,
    CFG_FB_TAPS = 1'b1
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FF,
    ST_FB,
    ST_DRAIN,
    ST_ROUND
  } state_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;    // zero the accumulator
    logic issue;    // start one product
    logic negate;   // subtract this product
  } mac_ctrl_t;

endpackage

// ===== rtl/iir_difference_equation_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_difference_equation_filter
// Direct form I IIR filter on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready with the kind in s_tuser: a sample,
// a feedforward or feedback coefficient load, or a history clear. Only a
// sample gives a result, on m_tvalid/m_tready: y[n] in m_tdata, clip flag in
// m_tuser. Loads and clears are taken while idle and give nothing.
// A sample visits each feedforward and feedback tap once on the shared
// multiplier, one tap per cycle, then drains the product register and rounds.
// nff and nfb, the tap counts, are clamped to 16. The next item is accepted
// once the sequencer is back in idle, after the result is registered.
// The result sits in an output register, so a new item is accepted while it
// waits; a stalled receiver holds the sequencer in the rounding step only
// when a second result is ready before the first is taken.
// ff_taps and fb_taps are written on cfg_we/cfg_index/cfg_data; the user must
// write them only while idle; the block itself does not enforce this.
// Reset (rst, synchronous) sets ff_taps to 1 and fb_taps to 0 and clears
// all histories and coefficients.
// ----------------------------------------------------------------------------
module iir_difference_equation_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input items
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // tap_index [3:0], coefficient [21:4], sample [37:22], zero [39:38]
  input  logic [iirdf_pkg::IN_TDATA_W-1:0]     s_tdata,
  // operation [1:0]
  input  logic [1:0]                           s_tuser,
  // Result items
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // filtered [15:0]
  output logic [iirdf_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // clipped [0]
  output logic                                 m_tuser,
  // Configuration
  input  logic                                 cfg_we,
  input  logic [iirdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iirdf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import iirdf_pkg::*;

  // Input fields
  op_t                         operation;
  logic [TAP_INDEX_W-1:0]      tap_index;
  logic signed [COEF_W-1:0]    coefficient;
  logic signed [SAMPLE_W-1:0]  sample;

  assign operation   = op_t'(s_tuser);
  assign tap_index   = s_tdata[TAP_INDEX_W-1:0];
  assign coefficient = s_tdata[TAP_INDEX_W +: COEF_W];
  assign sample      = s_tdata[TAP_INDEX_W + COEF_W +: SAMPLE_W];

  // Registers and state
  logic [TAPS_W-1:0]           ff_taps;
  logic [TAPS_W-1:0]           fb_taps;
  logic signed [SAMPLE_W-1:0]  in_hist   [MAX_FF_TAPS];
  logic signed [SAMPLE_W-1:0]  out_hist  [MAX_FB_TAPS];
  logic signed [COEF_W-1:0]    ff_coef   [MAX_FF_TAPS];
  logic signed [COEF_W-1:0]    fb_coef   [MAX_FB_TAPS];

  state_t                      state;
  state_t                      state_next;
  logic [IDX_W-1:0]            k;
  logic [IDX_W-1:0]            k_next;

  logic                        in_accept;
  logic                        sample_accept;
  logic                        out_free;
  logic                        load_out;
  logic [TAPS_W-1:0]           nff;
  logic [TAPS_W-1:0]           nfb;
  logic                        ff_last;
  logic                        fb_last;

  mac_ctrl_t                   mac_ctrl;
  logic signed [COEF_W-1:0]    mac_coef;
  logic signed [SAMPLE_W-1:0]  mac_data;
  logic signed [ACC_W-1:0]     acc;

  logic signed [ACC_W-1:0]     rounded;
  logic signed [ACC_W-FRAC_SHIFT-1:0] q;
  logic                        clip;
  logic signed [SAMPLE_W-1:0]  q_sat;

  assign in_accept     = s_tvalid && s_tready;
  assign sample_accept = in_accept && (operation == OP_SAMPLE);
  assign out_free      = !m_tvalid || m_tready;

  // Clamp tap counts to the storage size
  assign nff = (ff_taps > TAPS_W'(TAPS_FF_MAX)) ? TAPS_W'(TAPS_FF_MAX) : ff_taps;
  assign nfb = (fb_taps > TAPS_W'(TAPS_FB_MAX)) ? TAPS_W'(TAPS_FB_MAX) : fb_taps;
  assign ff_last = (TAPS_W'(k) == nff - TAPS_W'(1));
  assign fb_last = (TAPS_W'(k) == nfb - TAPS_W'(1));

  // Next state
  always_comb begin
    state_next = state;
    k_next     = k;
    unique case (state)
      ST_IDLE: begin
        if (sample_accept) begin
          k_next = '0;
          if (nff != '0) begin
            state_next = ST_FF;
          end else if (nfb != '0) begin
            state_next = ST_FB;
          end else begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_FF: begin
        k_next = k + IDX_W'(1);
        if (ff_last) begin
          k_next     = '0;
          state_next = (nfb != '0) ? ST_FB : ST_DRAIN;
        end
      end
      ST_FB: begin
        k_next = k + IDX_W'(1);
        if (fb_last) begin
          k_next     = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready        = 1'b0;
    load_out        = 1'b0;
    mac_ctrl.clear  = 1'b0;
    mac_ctrl.issue  = 1'b0;
    mac_ctrl.negate = 1'b0;
    mac_coef        = ff_coef[k];
    mac_data        = in_hist[k];
    unique case (state)
      ST_IDLE: begin
        s_tready       = 1'b1;
        mac_ctrl.clear = 1'b1;
      end
      ST_FF: begin
        mac_ctrl.issue = 1'b1;
      end
      ST_FB: begin
        mac_ctrl.issue  = 1'b1;
        mac_ctrl.negate = 1'b1;
        mac_coef        = fb_coef[k];
        mac_data        = out_hist[k];
      end
      ST_DRAIN: begin
      end
      ST_ROUND: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  // Shared multiply-accumulate
  iirdf_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .coef (mac_coef),
    .data (mac_data),
    .acc  (acc)
  );

  // Round half up, drop the fraction, saturate to Q1.15
  assign rounded = acc + ACC_W'(1 << (FRAC_SHIFT - 1));
  assign q       = rounded[ACC_W-1:FRAC_SHIFT];
  assign clip    = !((&q[ACC_W-FRAC_SHIFT-1:SAMPLE_W-1]) ||
                     (~|q[ACC_W-FRAC_SHIFT-1:SAMPLE_W-1]));
  assign q_sat   = !clip ? q[SAMPLE_W-1:0] :
                   (q[ACC_W-FRAC_SHIFT-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                          : {1'b0, {(SAMPLE_W-1){1'b1}}});

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ff_taps <= TAPS_W'(1);
      fb_taps <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FF_TAPS: ff_taps <= cfg_data;
        CFG_FB_TAPS: fb_taps <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Coefficient stores; every tap_index names a slot that exists
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FF_TAPS; i++) ff_coef[i] <= '0;
      for (int i = 0; i < MAX_FB_TAPS; i++) fb_coef[i] <= '0;
    end else if (in_accept) begin
      if (operation == OP_LOAD_FF) begin
        ff_coef[tap_index] <= coefficient;
      end
      if (operation == OP_LOAD_FB) begin
        fb_coef[tap_index] <= coefficient;
      end
    end
  end

  // Input history: shift the new sample in on acceptance
  always_ff @(posedge clk) begin
    if (rst || (in_accept && operation == OP_CLEAR)) begin
      for (int i = 0; i < MAX_FF_TAPS; i++) in_hist[i] <= '0;
    end else if (sample_accept) begin
      in_hist[0] <= sample;
      for (int i = 1; i < MAX_FF_TAPS; i++) in_hist[i] <= in_hist[i-1];
    end
  end

  // Output history: shift the saturated result in once it is final
  always_ff @(posedge clk) begin
    if (rst || (in_accept && operation == OP_CLEAR)) begin
      for (int i = 0; i < MAX_FB_TAPS; i++) out_hist[i] <= '0;
    end else if (load_out) begin
      out_hist[0] <= q_sat;
      for (int i = 1; i < MAX_FB_TAPS; i++) out_hist[i] <= out_hist[i-1];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= q_sat;
      m_tuser <= clip;
    end
  end

  // Checks
  a_out_from_round: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (m_tvalid && $past(state) == ST_ROUND))
    else $error("result loaded outside the rounding step");

  a_rise_needs_round: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_ROUND)
    else $error("result appeared without a finished sample");

  a_ff_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FF) |-> (TAPS_W'(k) < nff))
    else $error("feedforward index ran past tap count");

  a_clear_hist: assert property (@(posedge clk) disable iff (rst)
    (in_accept && operation == OP_CLEAR) |=> (in_hist[0] == '0 && out_hist[0] == '0))
    else $error("history not cleared");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    sample_accept |=> !s_tready)
    else $error("ready while a sample is in progress");

endmodule

// ===== rtl/iirdf_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf_mac
// Shared two-stage multiply-accumulate: registered product, then accumulate.
// ----------------------------------------------------------------------------
module iirdf_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  iirdf_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [iirdf_pkg::COEF_W-1:0]   coef,
  input  logic signed [iirdf_pkg::SAMPLE_W-1:0] data,
  output logic signed [iirdf_pkg::ACC_W-1:0]    acc
);
  import iirdf_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic                     prod_negate;

  // Stage one: register the product
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid  <= 1'b0;
      prod_negate <= 1'b0;
    end else begin
      prod_valid  <= ctrl.issue;
      prod_negate <= ctrl.negate;
    end
    prod <= coef * data;
  end

  // Stage two: add or subtract into the accumulator
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      if (prod_negate) begin
        acc <= acc - ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

endmodule

// ===== tb/sv/iir_filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_filter_checker
// Watches the item, result and register channels of the IIR filter, predicts
// each filtered sample from its own copy of the taps, coefficients and
// histories, and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module iir_filter_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [iirdf_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [1:0]                           s_tuser,
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [iirdf_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                 m_tuser,
  input  logic                                 cfg_we,
  input  logic [iirdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iirdf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                   fail_count,
  output int                                   pending
);
  import iirdf_pkg::*;

  localparam int COEF_LSB   = TAP_INDEX_W;
  localparam int SAMPLE_LSB = TAP_INDEX_W + COEF_W;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } filt_res_t;

  // Shadow of the filter state
  logic [TAPS_W-1:0]          ff_taps_q;
  logic [TAPS_W-1:0]          fb_taps_q;
  logic signed [SAMPLE_W-1:0] x_hist [MAX_FF_TAPS];
  logic signed [SAMPLE_W-1:0] y_hist [MAX_FB_TAPS];
  logic signed [COEF_W-1:0]   b_coef [MAX_FF_TAPS];
  logic signed [COEF_W-1:0]   a_coef [MAX_FB_TAPS];

  filt_res_t expected_y [$];

  // Compute y[n] for sample x, then shift both histories
  function automatic filt_res_t filter_step(logic signed [SAMPLE_W-1:0] x);
    longint    acc;
    longint    q;
    int        nff;
    int        nfb;
    int        k;
    filt_res_t r;
    nff = (ff_taps_q > MAX_FF_TAPS) ? MAX_FF_TAPS : int'(ff_taps_q);
    nfb = (fb_taps_q > MAX_FB_TAPS) ? MAX_FB_TAPS : int'(fb_taps_q);
    acc = 0;
    for (k = 0; k < nff; k++) begin
      if (k == 0) begin
        acc += longint'(b_coef[0]) * longint'(x);
      end else begin
        acc += longint'(b_coef[k]) * longint'(x_hist[k-1]);
      end
    end
    for (k = 0; k < nfb; k++) begin
      acc -= longint'(a_coef[k]) * longint'(y_hist[k]);
    end
    // round half up, floor shift to Q1.15, then saturate
    q = (acc + 64'sd8192) >>> FRAC_SHIFT;
    r.clipped = 1'b0;
    if (q > 32767) begin
      q = 32767;
      r.clipped = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      r.clipped = 1'b1;
    end
    r.filtered = q[SAMPLE_W-1:0];
    for (k = MAX_FF_TAPS - 1; k > 0; k--) x_hist[k] = x_hist[k-1];
    x_hist[0] = x;
    for (k = MAX_FB_TAPS - 1; k > 0; k--) y_hist[k] = y_hist[k-1];
    y_hist[0] = r.filtered;
    return r;
  endfunction

  task automatic report(string what, int want, int got);
    fail_count++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Track registers, retire results, predict new ones
  always @(posedge clk) begin : watch
    filt_res_t want;
    int        k;
    if (rst) begin
      ff_taps_q = TAPS_W'(1);
      fb_taps_q = '0;
      for (k = 0; k < MAX_FF_TAPS; k++) begin
        x_hist[k] = '0;
        b_coef[k] = '0;
      end
      for (k = 0; k < MAX_FB_TAPS; k++) begin
        y_hist[k] = '0;
        a_coef[k] = '0;
      end
      expected_y.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_FF_TAPS: ff_taps_q = cfg_data;
          CFG_FB_TAPS: fb_taps_q = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_y.size() == 0) begin
          report("unexpected result, filtered", 0, $signed(m_tdata));
        end else begin
          want = expected_y.pop_front();
          if (m_tdata !== want.filtered) begin
            report("filtered", want.filtered, $signed(m_tdata));
          end
          if (m_tuser !== want.clipped) begin
            report("clipped", want.clipped, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        case (op_t'(s_tuser))
          OP_SAMPLE: begin
            want       = filter_step(s_tdata[SAMPLE_LSB +: SAMPLE_W]);
            expected_y = {expected_y, want};
          end
          OP_LOAD_FF: b_coef[s_tdata[TAP_INDEX_W-1:0]] = s_tdata[COEF_LSB +: COEF_W];
          OP_LOAD_FB: a_coef[s_tdata[TAP_INDEX_W-1:0]] = s_tdata[COEF_LSB +: COEF_W];
          OP_CLEAR: begin
            for (k = 0; k < MAX_FF_TAPS; k++) x_hist[k] = '0;
            for (k = 0; k < MAX_FB_TAPS; k++) y_hist[k] = '0;
          end
          default: ;
        endcase
      end
    end
    pending <= expected_y.size();
  end

endmodule

// ===== tb/sv/tb_iir_difference_equation_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iir_difference_equation_filter
// Drives coefficient loads, history clears and samples into the IIR filter
// under a range of tap counts, with random gaps on both sides and a long
// receiver hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_iir_difference_equation_filter;
  import iirdf_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYC  = 40;
  localparam int HOLD_CYC    = 400;
  localparam int N_PHASES    = 12;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;

  int ff_list [8] = '{1, 16, 0, 31, 17, 0, 16, 2};
  int fb_list [8] = '{0, 16, 16, 31, 17, 0, 0, 1};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  iir_difference_equation_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  iir_filter_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offer one item, random gap if tx_idle; return once taken and ready is high
  task automatic send_item(op_t op, logic [3:0] slot, logic [17:0] coef,
                           logic [15:0] smp);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, smp, coef, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering, wait for every result, then let the sequencer go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_taps(logic [4:0] ff, logic [4:0] fb);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FF_TAPS;
    cfg_data  <= ff;
    @(posedge clk);
    cfg_index <= CFG_FB_TAPS;
    cfg_data  <= fb;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Tame coefficients keep the feedback loop mostly out of saturation
  function automatic logic [17:0] pick_coef(bit tame, bit feedback);
    if (!tame) return 18'($urandom);
    if (feedback) return 18'(int'($urandom_range(0, 1023)) - 512);
    return 18'(int'($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic logic [15:0] pick_sample(bit tame);
    if (tame && $urandom_range(0, 3) != 0) begin
      return 16'(int'($urandom_range(0, 16383)) - 8192);
    end
    return 16'($urandom);
  endfunction

  task automatic random_item(bit tame);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      send_item(OP_SAMPLE, 4'($urandom), 18'($urandom), pick_sample(tame));
    end else if (pick < 88) begin
      send_item(OP_LOAD_FF, 4'($urandom), pick_coef(tame, 1'b0), 16'($urandom));
    end else if (pick < 95) begin
      send_item(OP_LOAD_FB, 4'($urandom), pick_coef(tame, 1'b1), 16'($urandom));
    end else begin
      send_item(OP_CLEAR, 4'($urandom), 18'($urandom), 16'($urandom));
    end
  endtask

  // Receiver: random stall per result if rx_idle, plus a long hold-off on request
  initial begin : receiver
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    bit tame;
    int ph;
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset taps: one feedforward term, extremes, saturation and rounding
    send_item(OP_SAMPLE, 4'd0, 18'd0, 16'sd32767);
    send_item(OP_LOAD_FF, 4'd0, 18'sd131071, 16'd0);
    send_item(OP_SAMPLE, 4'd0, 18'd0, 16'sd32767);
    send_item(OP_SAMPLE, 4'd0, 18'd0, -16'sd32768);
    send_item(OP_LOAD_FF, 4'd0, -18'sd131072, 16'd0);
    send_item(OP_SAMPLE, 4'd0, 18'd0, -16'sd32768);
    send_item(OP_SAMPLE, 4'd0, 18'd0, 16'sd1);
    send_item(OP_LOAD_FF, 4'd0, 18'sd16384, 16'd0);
    send_item(OP_SAMPLE, 4'd0, 18'd0, 16'sd12345);
    send_item(OP_LOAD_FF, 4'd0, 18'sd8192, 16'd0);
    send_item(OP_SAMPLE, 4'd0, 18'd0, 16'sd1);
    send_item(OP_SAMPLE, 4'd0, 18'd0, -16'sd1);
    settle();

    // Full size with feedback, top slots, then a clear
    set_taps(5'd16, 5'd16);
    send_item(OP_LOAD_FF, 4'd15, 18'sd16384, 16'd0);
    send_item(OP_LOAD_FB, 4'd0, -18'sd8192, 16'd0);
    send_item(OP_LOAD_FB, 4'd15, 18'sd100, 16'd0);
    send_item(OP_LOAD_FF, 4'd0, 18'sd16384, 16'd0);
    send_item(OP_SAMPLE, 4'd0, 18'd0, 16'sd16000);
    send_item(OP_SAMPLE, 4'd0, 18'd0, 16'sd16000);
    send_item(OP_SAMPLE, 4'd0, 18'd0, -16'sd32768);
    send_item(OP_CLEAR, 4'd0, 18'd0, 16'd0);
    send_item(OP_SAMPLE, 4'd0, 18'd0, 16'sd100);
    settle();

    // No feedforward term: output comes from feedback only
    set_taps(5'd0, 5'd2);
    send_item(OP_SAMPLE, 4'd0, 18'd0, 16'sd1000);
    send_item(OP_SAMPLE, 4'd0, 18'd0, -16'sd5);
    settle();

    // Tap counts above the maximum act as the maximum
    set_taps(5'd31, 5'd31);
    send_item(OP_SAMPLE, 4'd0, 18'd0, 16'sd32767);
    send_item(OP_SAMPLE, 4'd0, 18'd0, 16'sd0);
    settle();

    // Random phases: clear, load every slot, then mostly samples
    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 8) begin
        set_taps(5'(ff_list[ph]), 5'(fb_list[ph]));
      end else begin
        set_taps(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      end
      tame    = ($urandom_range(0, 3) != 0);
      tx_idle = $urandom_range(0, 1);
      rx_idle = $urandom_range(0, 1);
      if (ph == 1 || ph == 9) hold_req = 1'b1;
      send_item(OP_CLEAR, 4'($urandom), 18'($urandom), 16'($urandom));
      for (k = 0; k < MAX_FF_TAPS; k++) begin
        send_item(OP_LOAD_FF, 4'(k), pick_coef(tame, 1'b0), 16'($urandom));
      end
      for (k = 0; k < MAX_FB_TAPS; k++) begin
        send_item(OP_LOAD_FB, 4'(k), pick_coef(tame, 1'b1), 16'($urandom));
      end
      repeat (68) random_item(tame);
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb_iir_difference_equation_filter OK");
    end else begin
      $display("tb_iir_difference_equation_filter NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_iir_difference_equation_filter NOT OK");
      $finish;
    end
  end

endmodule
